@@ src/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and constants of the text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;
  localparam int QUEUE_DEPTH = 2;
  localparam int TAB_STOP    = 8;

  localparam logic [7:0] CH_LINE_FEED = 8'd10;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  // register index, taken from paddr[2]
  localparam logic REG_TEXT_ATTR = 1'b0;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } tcw_op_e;

  typedef enum logic [2:0] {
    KIND_CHAR  = 3'd0,
    KIND_LF    = 3'd1,
    KIND_TAB   = 3'd2,
    KIND_SET   = 3'd3,
    KIND_CLEAR = 3'd4,
    KIND_READ  = 3'd5
  } tcw_kind_e;

  typedef enum logic [2:0] {
    ST_INIT   = 3'd0,
    ST_IDLE   = 3'd1,
    ST_EXEC   = 3'd2,
    ST_RDWAIT = 3'd3,
    ST_SCROLL = 3'd4,
    ST_FILL   = 3'd5
  } tcw_state_e;

  typedef struct packed {
    tcw_op_e     op;
    logic [7:0]  ch;
    logic [6:0]  col;
    logic [4:0]  row;
  } tcw_req_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        scrolled;
  } tcw_rsp_t;

  // classified request; col and row already saturated
  typedef struct packed {
    tcw_kind_e   kind;
    logic [7:0]  ch;
    logic [6:0]  col;
    logic [4:0]  row;
  } tcw_cmd_t;

  typedef struct packed {
    logic        empty;
    logic        full;
  } tcw_qstat_t;

endpackage

@@ src/tcw_front.sv @@
// ----------------------------------------------------------------------------
// tcw_front
// Takes requests, decodes them into commands and saturates col/row.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                start_i,
  input  tcw_pkg::tcw_req_t   req_i,
  input  tcw_pkg::tcw_qstat_t qstat_i,
  input  logic                init_busy_i,
  output logic                busy_o,
  output logic                push_o,
  output tcw_pkg::tcw_cmd_t   cmd_o
);
  import tcw_pkg::*;

  logic [31:0] col_ext;
  logic [31:0] row_ext;

  assign busy_o  = qstat_i.full | init_busy_i;
  assign push_o  = start_i & ~busy_o;
  assign col_ext = 32'(req_i.col);
  assign row_ext = 32'(req_i.row);

  always_comb begin
    cmd_o.ch  = req_i.ch;
    cmd_o.col = (col_ext > 32'(COLUMNS - 1)) ? 7'(COLUMNS - 1) : req_i.col;
    cmd_o.row = (row_ext > 32'(ROWS - 1)) ? 5'(ROWS - 1) : req_i.row;
    case (req_i.op)
      OP_PUT: begin
        if (req_i.ch == CH_LINE_FEED) begin
          cmd_o.kind = KIND_LF;
        end else if (req_i.ch == CH_TAB) begin
          cmd_o.kind = KIND_TAB;
        end else begin
          cmd_o.kind = KIND_CHAR;
        end
      end
      OP_SET:   cmd_o.kind = KIND_SET;
      OP_CLEAR: cmd_o.kind = KIND_CLEAR;
      OP_READ:  cmd_o.kind = KIND_READ;
      default:  cmd_o.kind = KIND_READ;
    endcase
  end

endmodule

@@ src/tcw_queue.sv @@
// ----------------------------------------------------------------------------
// tcw_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tcw_pkg::tcw_cmd_t   cmd_i,
  input  logic                pop_i,
  output tcw_pkg::tcw_cmd_t   cmd_o,
  output tcw_pkg::tcw_qstat_t qstat_o
);
  import tcw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tcw_cmd_t           entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wptr_q, wptr_d;
  logic [PTR_W-1:0]   rptr_q, rptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (32'(p) == QUEUE_DEPTH - 1) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign cmd_o         = entry_q[rptr_q];
  assign qstat_o.empty = (count_q == '0);
  assign qstat_o.full  = (32'(count_q) == QUEUE_DEPTH);

  always_comb begin
    wptr_d  = push_i ? ptr_inc(wptr_q) : wptr_q;
    rptr_d  = pop_i ? ptr_inc(rptr_q) : rptr_q;
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

endmodule

@@ src/tcw_back.sv @@
// ----------------------------------------------------------------------------
// tcw_back
// Command engine: cursor, screen memory, scroll copy and fill sweeps.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        text_attr_i,
  input  tcw_pkg::tcw_cmd_t head_i,
  input  logic              head_valid_i,
  output logic              pop_o,
  output logic              init_busy_o,
  output logic              rsp_valid_o,
  output tcw_pkg::tcw_rsp_t rsp_o
);
  import tcw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int COPY_N = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  tcw_state_e         state_q, state_d;
  tcw_cmd_t           cmd_q, cmd_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [ADDR_W-1:0]  off_q, off_d;
  logic [ADDR_W-1:0]  ptr_q, ptr_d;
  logic               scrolled_q, scrolled_d;
  logic               cp_valid_q, cp_valid_d;
  logic [ADDR_W-1:0]  cp_addr_q, cp_addr_d;
  logic               rsp_valid_q, rsp_valid_d;
  tcw_rsp_t           rsp_q, rsp_d;

  logic [15:0]        mem [CELLS];
  logic [15:0]        rdata_q;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [15:0]        mem_wdata;

  // cursor after a put command
  logic [31:0]        adv_col, adv_row, adv_off;
  logic               adv_scroll;
  logic [31:0]        cmd_off;

  assign init_busy_o = (state_q == ST_INIT);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign cmd_off     = 32'(cmd_q.row) * 32'(COLUMNS) + 32'(cmd_q.col);

  always_comb begin
    adv_col = 32'(col_q);
    adv_row = 32'(row_q);
    adv_off = 32'(off_q);
    case (cmd_q.kind)
      KIND_CHAR: begin
        adv_col = 32'(col_q) + 32'd1;
        adv_off = 32'(off_q) + 32'd1;
        if (adv_col == 32'(COLUMNS)) begin
          adv_col = '0;
          adv_row = 32'(row_q) + 32'd1;
        end
      end
      KIND_LF: begin
        adv_col = '0;
        adv_row = 32'(row_q) + 32'd1;
        adv_off = 32'(off_q) + 32'(COLUMNS) - 32'(col_q);
      end
      KIND_TAB: begin
        // tab stop is taken on the linear offset, may wrap to next row
        adv_col = 32'(col_q) + 32'(TAB_STOP) - (32'(off_q) & 32'(TAB_STOP - 1));
        adv_off = (32'(off_q) & ~32'(TAB_STOP - 1)) + 32'(TAB_STOP);
        if (adv_col >= 32'(COLUMNS)) begin
          adv_col = adv_col - 32'(COLUMNS);
          adv_row = 32'(row_q) + 32'd1;
        end
      end
      default: begin
        adv_col = 32'(col_q);
      end
    endcase
    adv_scroll = (adv_row >= 32'(ROWS));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (32'(ptr_q) == CELLS - 1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (head_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (cmd_q.kind)
          KIND_CHAR, KIND_LF, KIND_TAB: state_d = adv_scroll ? ST_SCROLL : ST_IDLE;
          KIND_READ:  state_d = ST_RDWAIT;
          KIND_CLEAR: state_d = ST_FILL;
          default:    state_d = ST_IDLE;
        endcase
      end
      ST_RDWAIT: state_d = ST_IDLE;
      ST_SCROLL: begin
        if (32'(ptr_q) == COPY_N) state_d = ST_FILL;
      end
      ST_FILL: begin
        if (32'(ptr_q) == CELLS - 1) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic [31:0] col_ext;
    logic [31:0] row_ext;
    cmd_d       = cmd_q;
    col_d       = col_q;
    row_d       = row_q;
    off_d       = off_q;
    ptr_d       = ptr_q;
    scrolled_d  = scrolled_q;
    cp_valid_d  = 1'b0;
    cp_addr_d   = cp_addr_q;
    rsp_valid_d = 1'b0;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = ptr_q;
    mem_raddr   = ADDR_W'(32'(ptr_q) + 32'(COLUMNS));
    mem_wdata   = {text_attr_i, CH_SPACE};
    rsp_d.cell_char = '0;
    rsp_d.cell_attr = '0;
    rsp_d.scrolled  = 1'b0;

    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {RESET_ATTR, CH_SPACE};
        ptr_d     = ptr_q + 1'b1;
      end
      ST_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          cmd_d = head_i;
        end
      end
      ST_EXEC: begin
        case (cmd_q.kind)
          KIND_CHAR, KIND_LF, KIND_TAB: begin
            if (cmd_q.kind == KIND_CHAR) begin
              mem_we    = 1'b1;
              mem_waddr = off_q;
              mem_wdata = {text_attr_i, cmd_q.ch};
            end
            if (adv_scroll) begin
              col_d      = '0;
              row_d      = ROW_W'(ROWS - 1);
              off_d      = ADDR_W'(COPY_N);
              ptr_d      = '0;
              scrolled_d = 1'b1;
            end else begin
              col_d       = COL_W'(adv_col);
              row_d       = ROW_W'(adv_row);
              off_d       = ADDR_W'(adv_off);
              rsp_valid_d = 1'b1;
            end
          end
          KIND_SET: begin
            col_d       = COL_W'(cmd_q.col);
            row_d       = ROW_W'(cmd_q.row);
            off_d       = ADDR_W'(cmd_off);
            rsp_valid_d = 1'b1;
          end
          KIND_READ: begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(cmd_off);
          end
          KIND_CLEAR: begin
            col_d      = '0;
            row_d      = '0;
            off_d      = '0;
            ptr_d      = '0;
            scrolled_d = 1'b0;
          end
          default: begin
            rsp_valid_d = 1'b1;
          end
        endcase
      end
      ST_RDWAIT: begin
        rsp_valid_d     = 1'b1;
        rsp_d.cell_char = rdata_q[7:0];
        rsp_d.cell_attr = rdata_q[15:8];
      end
      ST_SCROLL: begin
        // read row below, write it one row up in the next cycle
        if (32'(ptr_q) < COPY_N) begin
          mem_re     = 1'b1;
          cp_valid_d = 1'b1;
          cp_addr_d  = ptr_q;
          ptr_d      = ptr_q + 1'b1;
        end
        if (cp_valid_q) begin
          mem_we    = 1'b1;
          mem_waddr = cp_addr_q;
          mem_wdata = rdata_q;
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + 1'b1;
        if (32'(ptr_q) == CELLS - 1) begin
          rsp_valid_d    = 1'b1;
          rsp_d.scrolled = scrolled_q;
        end
      end
      default: begin
        rsp_valid_d = 1'b0;
      end
    endcase

    col_ext          = 32'(col_d);
    row_ext          = 32'(row_d);
    rsp_d.cursor_col = col_ext[6:0];
    rsp_d.cursor_row = row_ext[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      col_q       <= '0;
      row_q       <= '0;
      off_q       <= '0;
      ptr_q       <= '0;
      scrolled_q  <= 1'b0;
      cp_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      off_q       <= off_d;
      ptr_q       <= ptr_d;
      scrolled_q  <= scrolled_d;
      cp_valid_q  <= cp_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    cp_addr_q <= cp_addr_d;
    rsp_q     <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

endmodule

@@ src/text_console_char_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console of COLUMNS x ROWS character/attribute cells with a cursor.
//
//   channel  | handshake                       | payload
//   ---------+---------------------------------+---------------------------
//   request  | start, busy (taken: start&!busy) | req_i   (op, ch, col, row)
//   result   | rsp_valid_o, one-cycle strobe    | rsp_o   (cursor, cell, scrolled)
//   config   | APB write, pready always high   | pwdata  (text_attr at 0x0)
//
// Put, set cursor: the request is queued, taken into the back's command register, executed
// and its result registered (a put that scrolls answers after the sweeps); read cell adds a
// wait state for the registered memory read. The back takes a new command only when idle.
// Scroll: a copy sweep one row up, then a fill of the last row; clear: a fill of every cell;
// both on the single screen memory. After reset a clearing pass runs with busy high.
// busy is high while the two-entry request queue is full. Results cannot stall.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tcw_pkg::tcw_req_t req_i,
  output logic              rsp_valid_o,
  output tcw_pkg::tcw_rsp_t rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import tcw_pkg::*;

  logic       [7:0] text_attr_q, text_attr_d;
  logic             cfg_we;
  logic             push;
  logic             pop;
  logic             init_busy;
  tcw_cmd_t         front_cmd;
  tcw_cmd_t         head_cmd;
  tcw_qstat_t       qstat;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready & (paddr[2] == REG_TEXT_ATTR);
  assign text_attr_d = cfg_we ? pwdata[7:0] : text_attr_q;
  assign prdata = (paddr[2] == REG_TEXT_ATTR) ? {24'd0, text_attr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q <= RESET_ATTR;
    end else begin
      text_attr_q <= text_attr_d;
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .start_i     (start),
    .req_i       (req_i),
    .qstat_i     (qstat),
    .init_busy_i (init_busy),
    .busy_o      (busy),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  tcw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .qstat_o (qstat)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_attr_i  (text_attr_q),
    .head_i       (head_cmd),
    .head_valid_i (~qstat.empty),
    .pop_o        (pop),
    .init_busy_o  (init_busy),
    .rsp_valid_o  (rsp_valid_o),
    .rsp_o        (rsp_o)
  );

endmodule
